### src/sahl_pkg.sv
// ----------------------------------------------------------------------------
// Sensor alarm history log package
// Shared widths, codes and record layout for the alarm history log.
// ----------------------------------------------------------------------------
`default_nettype none

package sahl_pkg;

  localparam int HISTORY_DEPTH = 10;
  localparam int SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int COUNT_W = $clog2(HISTORY_DEPTH + 1);

  localparam int MODE_W = 2;
  localparam int DEV_W = 4;
  localparam int TIME_W = 32;
  localparam int READING_W = 14;
  localparam int KIND_W = 2;
  localparam int POSITION_W = 4;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_NEWEST = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ALL = 2'd2;

  localparam logic [KIND_W-1:0] KIND_ACK = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RECORD = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd2;

  localparam logic [READING_W-1:0] LIMIT_RESET = 14'd5000;

  typedef struct packed {
    logic [DEV_W-1:0]     dev;
    logic [TIME_W-1:0]    stamp;
    logic [READING_W-1:0] value;
  } sahl_rec_t;

  typedef struct packed {
    logic [READING_W-1:0] temperature;
    logic [READING_W-1:0] humidity;
  } sahl_limits_t;

endpackage

`default_nettype wire

### src/sahl_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module sahl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### src/sahl_cfg.sv
// ----------------------------------------------------------------------------
// Alarm limit registers
// APB-style register file holding the temperature and humidity limits.
// ----------------------------------------------------------------------------
`default_nettype none

module sahl_cfg
  import sahl_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  output sahl_limits_t            limits
);

  sahl_limits_t limits_r;
  sahl_limits_t limits_nxt;
  logic         wr_en;

  assign wr_en = psel && penable && pwrite;
  assign pready = 1'b1;
  assign limits = limits_r;

  always_comb begin
    limits_nxt = limits_r;
    if (wr_en) begin
      if (paddr[2]) begin
        limits_nxt.humidity = pwdata[READING_W-1:0];
      end else begin
        limits_nxt.temperature = pwdata[READING_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2]) begin
      prdata = PDATA_W'(limits_r.humidity);
    end else begin
      prdata = PDATA_W'(limits_r.temperature);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limits_r.temperature <= LIMIT_RESET;
      limits_r.humidity <= LIMIT_RESET;
    end else begin
      limits_r <= limits_nxt;
    end
  end

endmodule

`default_nettype wire

### src/sahl_seq.sv
// ----------------------------------------------------------------------------
// Alarm history sequencer
// Logs alarms into the history RAM and walks it for readout requests.
// ----------------------------------------------------------------------------
`default_nettype none

module sahl_seq
  import sahl_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [MODE_W-1:0]     in_mode,
  input  wire logic [DEV_W-1:0]      in_device_id,
  input  wire logic [TIME_W-1:0]     in_timestamp,
  input  wire logic [READING_W-1:0]  in_temperature,
  input  wire logic [READING_W-1:0]  in_humidity,
  input  wire sahl_limits_t          limits,
  output logic                       out_valid,
  output logic      [KIND_W-1:0]     out_kind,
  output logic                       out_temperature_alarm,
  output logic                       out_humidity_alarm,
  output logic      [POSITION_W-1:0] out_position,
  output logic      [DEV_W-1:0]      out_record_device,
  output logic      [TIME_W-1:0]     out_record_time,
  output logic      [READING_W-1:0]  out_record_value,
  output logic                       out_last_of_run
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_TEMP = 2'd1;
  localparam logic [1:0] ST_HUM = 2'd2;
  localparam logic [1:0] ST_READ = 2'd3;

  logic [1:0]           state_r, state_nxt;
  logic [SLOT_W-1:0]    newest_r, newest_nxt;
  logic [COUNT_W-1:0]   count_r, count_nxt;
  logic [SLOT_W-1:0]    cursor_r, cursor_nxt;
  logic [COUNT_W-1:0]   rank_r, rank_nxt;
  logic                 single_r, single_nxt;
  logic                 ta_r, ta_nxt;
  logic                 ha_r, ha_nxt;
  logic [DEV_W-1:0]     dev_r, dev_nxt;
  logic [TIME_W-1:0]    stamp_r, stamp_nxt;
  logic [READING_W-1:0] temp_r, temp_nxt;
  logic [READING_W-1:0] hum_r, hum_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0]     out_kind_r, out_kind_nxt;
  logic                  out_ta_r, out_ta_nxt;
  logic                  out_ha_r, out_ha_nxt;
  logic [POSITION_W-1:0] out_pos_r, out_pos_nxt;
  sahl_rec_t             out_rec_r, out_rec_nxt;
  logic                  out_last_r, out_last_nxt;

  logic              accept;
  logic [SLOT_W-1:0] append_slot;
  logic [SLOT_W-1:0] prev_slot;
  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  sahl_rec_t         ram_wdata;
  logic              ram_re;
  logic [SLOT_W-1:0] ram_raddr;
  sahl_rec_t         ram_rdata;
  logic              read_last;

  sahl_ram #(
    .WIDTH($bits(sahl_rec_t)),
    .DEPTH(HISTORY_DEPTH)
  ) u_history (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign busy = (state_r != ST_IDLE);
  assign accept = start && !busy;

  always_comb begin
    if (count_r == '0 || newest_r == SLOT_W'(HISTORY_DEPTH - 1)) begin
      append_slot = '0;
    end else begin
      append_slot = newest_r + 1'b1;
    end
    if (cursor_r == '0) begin
      prev_slot = SLOT_W'(HISTORY_DEPTH - 1);
    end else begin
      prev_slot = cursor_r - 1'b1;
    end
  end

  assign read_last = single_r || (rank_r == count_r);

  always_comb begin
    state_nxt = state_r;
    newest_nxt = newest_r;
    count_nxt = count_r;
    cursor_nxt = cursor_r;
    rank_nxt = rank_r;
    single_nxt = single_r;
    ta_nxt = ta_r;
    ha_nxt = ha_r;
    dev_nxt = dev_r;
    stamp_nxt = stamp_r;
    temp_nxt = temp_r;
    hum_nxt = hum_r;

    out_valid_nxt = 1'b0;
    out_kind_nxt = out_kind_r;
    out_ta_nxt = out_ta_r;
    out_ha_nxt = out_ha_r;
    out_pos_nxt = out_pos_r;
    out_rec_nxt = out_rec_r;
    out_last_nxt = out_last_r;

    ram_we = 1'b0;
    ram_waddr = append_slot;
    ram_wdata = '{dev: dev_r, stamp: stamp_r, value: temp_r};
    ram_re = 1'b0;
    ram_raddr = newest_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          dev_nxt = in_device_id;
          stamp_nxt = in_timestamp;
          temp_nxt = in_temperature;
          hum_nxt = in_humidity;
          ta_nxt = in_temperature > limits.temperature;
          ha_nxt = in_humidity > limits.humidity;
          single_nxt = (in_mode == MODE_NEWEST);
          if (in_mode == MODE_SAMPLE) begin
            state_nxt = ST_TEMP;
          end else if (in_mode == MODE_NEWEST || in_mode == MODE_ALL) begin
            if (count_r == '0) begin
              out_valid_nxt = 1'b1;
              out_kind_nxt = KIND_NONE;
              out_ta_nxt = 1'b0;
              out_ha_nxt = 1'b0;
              out_pos_nxt = '0;
              out_rec_nxt = '0;
              out_last_nxt = 1'b1;
            end else begin
              ram_re = 1'b1;
              ram_raddr = newest_r;
              cursor_nxt = newest_r;
              rank_nxt = COUNT_W'(1);
              state_nxt = ST_READ;
            end
          end
        end
      end
      ST_TEMP: begin
        if (ta_r) begin
          ram_we = 1'b1;
          newest_nxt = append_slot;
          if (count_r < COUNT_W'(HISTORY_DEPTH)) begin
            count_nxt = count_r + 1'b1;
          end
        end
        state_nxt = ST_HUM;
      end
      ST_HUM: begin
        ram_wdata = '{dev: dev_r, stamp: stamp_r, value: hum_r};
        if (ha_r) begin
          ram_we = 1'b1;
          newest_nxt = append_slot;
          if (count_r < COUNT_W'(HISTORY_DEPTH)) begin
            count_nxt = count_r + 1'b1;
          end
        end
        out_valid_nxt = 1'b1;
        out_kind_nxt = KIND_ACK;
        out_ta_nxt = ta_r;
        out_ha_nxt = ha_r;
        out_pos_nxt = '0;
        out_rec_nxt = '0;
        out_last_nxt = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_READ: begin
        out_valid_nxt = 1'b1;
        out_kind_nxt = KIND_RECORD;
        out_ta_nxt = 1'b0;
        out_ha_nxt = 1'b0;
        out_pos_nxt = POSITION_W'(rank_r);
        out_rec_nxt = ram_rdata;
        out_last_nxt = read_last;
        if (read_last) begin
          state_nxt = ST_IDLE;
        end else begin
          ram_re = 1'b1;
          ram_raddr = prev_slot;
          cursor_nxt = prev_slot;
          rank_nxt = rank_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      newest_r <= '0;
      count_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      newest_r <= newest_nxt;
      count_r <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cursor_r <= cursor_nxt;
    rank_r <= rank_nxt;
    single_r <= single_nxt;
    ta_r <= ta_nxt;
    ha_r <= ha_nxt;
    dev_r <= dev_nxt;
    stamp_r <= stamp_nxt;
    temp_r <= temp_nxt;
    hum_r <= hum_nxt;
    out_kind_r <= out_kind_nxt;
    out_ta_r <= out_ta_nxt;
    out_ha_r <= out_ha_nxt;
    out_pos_r <= out_pos_nxt;
    out_rec_r <= out_rec_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_kind = out_kind_r;
  assign out_temperature_alarm = out_ta_r;
  assign out_humidity_alarm = out_ha_r;
  assign out_position = out_pos_r;
  assign out_record_device = out_rec_r.dev;
  assign out_record_time = out_rec_r.stamp;
  assign out_record_value = out_rec_r.value;
  assign out_last_of_run = out_last_r;

endmodule

`default_nettype wire

### src/sensor_alarm_history_log.sv
// ----------------------------------------------------------------------------
// Sensor alarm history log
// Keeps the newest alarm records of a sensor network and reads them back.
// ----------------------------------------------------------------------------
//   Channel   Handshake                    Carries
//   in_*      start / busy                 mode, device, time, readings
//   out_*     out_valid, one-cycle strobe  kind, flags, rank, record, last
//   APB       psel, penable, pready        temperature and humidity limits
//
// A sample passes through a temperature write state and a humidity write state
// before the next acceptance, since the history RAM has one write port and
// each alarm takes one write. A readout makes one RAM read per record.
// An empty-history read or an unused mode leaves the block idle.
// Reset is synchronous and needs no clearing pass.
// Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_alarm_history_log
  import sahl_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [MODE_W-1:0]     in_mode,
  input  wire logic [DEV_W-1:0]      in_device_id,
  input  wire logic [TIME_W-1:0]     in_timestamp,
  input  wire logic [READING_W-1:0]  in_temperature,
  input  wire logic [READING_W-1:0]  in_humidity,
  output logic                       out_valid,
  output logic      [KIND_W-1:0]     out_kind,
  output logic                       out_temperature_alarm,
  output logic                       out_humidity_alarm,
  output logic      [POSITION_W-1:0] out_position,
  output logic      [DEV_W-1:0]      out_record_device,
  output logic      [TIME_W-1:0]     out_record_time,
  output logic      [READING_W-1:0]  out_record_value,
  output logic                       out_last_of_run,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [PADDR_W-1:0]    paddr,
  input  wire logic [PDATA_W-1:0]    pwdata,
  output logic      [PDATA_W-1:0]    prdata,
  output logic                       pready
);

  sahl_limits_t limits;

  sahl_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .limits (limits)
  );

  sahl_seq u_seq (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_mode              (in_mode),
    .in_device_id         (in_device_id),
    .in_timestamp         (in_timestamp),
    .in_temperature       (in_temperature),
    .in_humidity          (in_humidity),
    .limits               (limits),
    .out_valid            (out_valid),
    .out_kind             (out_kind),
    .out_temperature_alarm(out_temperature_alarm),
    .out_humidity_alarm   (out_humidity_alarm),
    .out_position         (out_position),
    .out_record_device    (out_record_device),
    .out_record_time      (out_record_time),
    .out_record_value     (out_record_value),
    .out_last_of_run      (out_last_of_run)
  );

endmodule

`default_nettype wire

### src/sahl_checker.sv
// ----------------------------------------------------------------------------
// Sensor alarm history log checker
// Port-level properties of the alarm history log, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sahl_checker
  import sahl_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  start,
  input wire logic                  busy,
  input wire logic [MODE_W-1:0]     in_mode,
  input wire logic                  out_valid,
  input wire logic [KIND_W-1:0]     out_kind,
  input wire logic [POSITION_W-1:0] out_position,
  input wire logic [DEV_W-1:0]      out_record_device,
  input wire logic [TIME_W-1:0]     out_record_time,
  input wire logic [READING_W-1:0]  out_record_value,
  input wire logic                  out_last_of_run
);

  a_ack_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_ACK |-> out_last_of_run && out_position == '0)
    else $error("sample acknowledgement is not a single unranked result");

  a_none_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_NONE |->
      out_last_of_run && out_record_device == '0 && out_record_time == '0 &&
      out_record_value == '0)
    else $error("empty-history result carries record data");

  a_rank_steps: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_of_run |=>
      out_valid && out_kind == KIND_RECORD &&
      out_position == $past(out_position) + 1'b1)
    else $error("readout run broke off or skipped a rank");

  a_record_ranked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_RECORD && out_position == 4'd1 |->
      $past(start && !busy && (in_mode == MODE_NEWEST || in_mode == MODE_ALL), 2))
    else $error("first record did not follow a readout request");

  a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_mode == MODE_SAMPLE |=> busy)
    else $error("sample request did not occupy the block");

endmodule

bind sensor_alarm_history_log sahl_checker u_sahl_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_mode          (in_mode),
  .out_valid        (out_valid),
  .out_kind         (out_kind),
  .out_position     (out_position),
  .out_record_device(out_record_device),
  .out_record_time  (out_record_time),
  .out_record_value (out_record_value),
  .out_last_of_run  (out_last_of_run)
);

`default_nettype wire
